>>> sv/fpes_pkg.sv
package fpes_pkg;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned DataW  = 64;
  localparam int unsigned HalfW  = 16;
  localparam int unsigned StepW  = 16;
  localparam int unsigned CountW = 8;

  localparam logic [AddrW-1:0]  NoAddress     = '1;
  localparam logic [AddrW-1:0]  HalfWordStep  = AddrW'(2);
  localparam logic [StepW-1:0]  PageStepReset = StepW'(1024);

  typedef enum logic [1:0] {
    FuncProgram   = 2'd0,
    FuncPageErase = 2'd1,
    FuncMassErase = 2'd2,
    FuncComplete  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    WidthHalf   = 2'd0,
    WidthWord   = 2'd1,
    WidthDouble = 2'd2,
    WidthWide   = 2'd3
  } width_e;

  typedef enum logic [1:0] {
    KindNone = 2'd0,
    KindProg = 2'd1,
    KindPage = 2'd2,
    KindMass = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CmdNone     = 2'd0,
    CmdWriteHw  = 2'd1,
    CmdErasePg  = 2'd2,
    CmdEraseAll = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    FaultNone    = 2'd0,
    FaultProtect = 2'd1,
    FaultProgram = 2'd2,
    FaultSpare   = 2'd3
  } fault_e;

  typedef struct packed {
    func_e              func;
    width_e             width;
    logic [AddrW-1:0]   start_address;
    logic [DataW-1:0]   payload;
    logic [CountW-1:0]  page_count;
    logic               protect_fault;
    logic               program_fault;
  } item_t;

  typedef struct packed {
    cmd_e               command;
    logic [AddrW-1:0]   command_address;
    logic [HalfW-1:0]   command_data;
    logic               job_done;
    fault_e             fault_code;
    logic [AddrW-1:0]   fault_address;
    logic               active;
  } result_t;

endpackage

>>> sv/flash_program_erase_sequencer_unit.sv
// An item passes the input register, then the result register, before its
// result is presented; out_ready_i low can hold it in between.
// Throughput: one item per cycle; the input stage refills in the cycle the
// result register is freed, so only out_ready_i low stalls the block.
// Reset (rst_ni low, asynchronous): no job, page step 1024, both stages empty.
module flash_program_erase_sequencer_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       func_i,
  input  logic [1:0]                       width_i,
  input  logic [fpes_pkg::AddrW-1:0]       start_address_i,
  input  logic [fpes_pkg::DataW-1:0]       payload_i,
  input  logic [fpes_pkg::CountW-1:0]      page_count_i,
  input  logic                             protect_fault_i,
  input  logic                             program_fault_i,
  input  logic                             cfg_we_i,
  input  logic [fpes_pkg::StepW-1:0]       cfg_wdata_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       command_o,
  output logic [fpes_pkg::AddrW-1:0]       command_address_o,
  output logic [fpes_pkg::HalfW-1:0]       command_data_o,
  output logic                             job_done_o,
  output logic [1:0]                       fault_code_o,
  output logic [fpes_pkg::AddrW-1:0]       fault_address_o,
  output logic                             active_o
);

  fpes_pkg::item_t   in_item, stage_item;
  fpes_pkg::result_t core_res, res_q;
  logic              stage_valid, advance;
  logic              out_valid_d, out_valid_q;

  always_comb begin
    in_item.func          = fpes_pkg::func_e'(func_i);
    in_item.width         = fpes_pkg::width_e'(width_i);
    in_item.start_address = start_address_i;
    in_item.payload       = payload_i;
    in_item.page_count    = page_count_i;
    in_item.protect_fault = protect_fault_i;
    in_item.program_fault = program_fault_i;
  end

  // advance when the result register is empty or being drained
  assign advance = stage_valid && (!out_valid_q || out_ready_i);

  fpes_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  fpes_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (advance),
    .item_i      (stage_item),
    .result_o    (core_res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= core_res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign command_o         = res_q.command;
  assign command_address_o = res_q.command_address;
  assign command_data_o    = res_q.command_data;
  assign job_done_o        = res_q.job_done;
  assign fault_code_o      = res_q.fault_code;
  assign fault_address_o   = res_q.fault_address;
  assign active_o          = res_q.active;

endmodule

>>> sv/fpes_in_stage.sv
module fpes_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fpes_pkg::item_t item_i,
  input  logic          advance_i,
  output logic          valid_o,
  output fpes_pkg::item_t item_o
);

  logic            valid_d, valid_q;
  fpes_pkg::item_t item_q;
  logic            take;

  assign in_ready_o = !valid_q || advance_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // hold the item until the core consumes it
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> sv/fpes_core.sv
module fpes_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fpes_pkg::StepW-1:0]    cfg_wdata_i,
  input  logic                          step_i,
  input  fpes_pkg::item_t               item_i,
  output fpes_pkg::result_t             result_o
);

  fpes_pkg::kind_e                  kind_d, kind_q;
  logic [fpes_pkg::CountW-1:0]      steps_d, steps_q;
  logic [fpes_pkg::AddrW-1:0]       addr_d, addr_q;
  logic [fpes_pkg::DataW-1:0]       data_d, data_q;
  logic [fpes_pkg::StepW-1:0]       page_step_q;
  logic [fpes_pkg::CountW-1:0]      steps_dec;
  logic [fpes_pkg::DataW-1:0]       data_shift;
  fpes_pkg::result_t                res;

  assign steps_dec  = steps_q - fpes_pkg::CountW'(1);
  assign data_shift = data_q >> fpes_pkg::HalfW;

  always_comb begin
    kind_d  = kind_q;
    steps_d = steps_q;
    addr_d  = addr_q;
    data_d  = data_q;
    res     = '0;
    case (item_i.func)
      fpes_pkg::FuncProgram: begin
        kind_d = fpes_pkg::KindProg;
        case (item_i.width)
          fpes_pkg::WidthHalf: steps_d = fpes_pkg::CountW'(1);
          fpes_pkg::WidthWord: steps_d = fpes_pkg::CountW'(2);
          default:             steps_d = fpes_pkg::CountW'(4);
        endcase
        addr_d              = item_i.start_address;
        data_d              = item_i.payload;
        res.command         = fpes_pkg::CmdWriteHw;
        res.command_address = item_i.start_address;
        res.command_data    = item_i.payload[fpes_pkg::HalfW-1:0];
      end
      fpes_pkg::FuncPageErase: begin
        kind_d              = fpes_pkg::KindPage;
        steps_d             = (item_i.page_count == '0) ? fpes_pkg::CountW'(1)
                                                        : item_i.page_count;
        addr_d              = item_i.start_address;
        res.command         = fpes_pkg::CmdErasePg;
        res.command_address = item_i.start_address;
      end
      fpes_pkg::FuncMassErase: begin
        kind_d      = fpes_pkg::KindMass;
        steps_d     = fpes_pkg::CountW'(1);
        addr_d      = fpes_pkg::NoAddress;
        res.command = fpes_pkg::CmdEraseAll;
      end
      default: begin
        if (item_i.protect_fault || item_i.program_fault) begin
          // abort: report where the failing step was
          res.fault_code    = item_i.program_fault ? fpes_pkg::FaultProgram
                                                   : fpes_pkg::FaultProtect;
          res.fault_address = addr_q;
          kind_d            = fpes_pkg::KindNone;
          steps_d           = '0;
          addr_d            = fpes_pkg::NoAddress;
        end else if (kind_q == fpes_pkg::KindPage || kind_q == fpes_pkg::KindProg) begin
          steps_d = steps_dec;
          if (steps_dec != '0) begin
            if (kind_q == fpes_pkg::KindPage) begin
              addr_d      = addr_q + {{(fpes_pkg::AddrW-fpes_pkg::StepW){1'b0}}, page_step_q};
              res.command = fpes_pkg::CmdErasePg;
            end else begin
              addr_d           = addr_q + fpes_pkg::HalfWordStep;
              data_d           = data_shift;
              res.command      = fpes_pkg::CmdWriteHw;
              res.command_data = data_shift[fpes_pkg::HalfW-1:0];
            end
            res.command_address = addr_d;
          end else begin
            res.job_done = 1'b1;
            kind_d       = fpes_pkg::KindNone;
            addr_d       = fpes_pkg::NoAddress;
          end
        end else if (kind_q == fpes_pkg::KindMass) begin
          res.job_done = 1'b1;
          kind_d       = fpes_pkg::KindNone;
          steps_d      = '0;
          addr_d       = fpes_pkg::NoAddress;
        end
      end
    endcase
    res.active = (kind_d != fpes_pkg::KindNone);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= fpes_pkg::KindNone;
      steps_q <= '0;
      addr_q  <= fpes_pkg::NoAddress;
      data_q  <= '0;
    end else if (step_i) begin
      kind_q  <= kind_d;
      steps_q <= steps_d;
      addr_q  <= addr_d;
      data_q  <= data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_step_q <= fpes_pkg::PageStepReset;
    end else if (cfg_we_i) begin
      page_step_q <= cfg_wdata_i;
    end
  end

  assign result_o = res;

endmodule
